@@ rtl/core/rbm_pkg.sv @@
package rbm_pkg;

	localparam int RBM_MAX_BLOCKS = 8;
	localparam int START_W = 16;
	localparam int SEG_LEN_W = 17;
	localparam int ENT_LEN_W = 18;
	localparam int RING_W = 17;
	localparam int OUT_W = 18;
	localparam int DIST_W = 21;
	localparam logic [RING_W-1:0] RING_RESET = 17'd65536;

	typedef logic signed [DIST_W-1:0] dist_t;

	typedef struct packed {
		logic [START_W-1:0] start;
		logic [ENT_LEN_W-1:0] len;
	} rbm_entry_t;

	function automatic dist_t dist_from(input logic [START_W-1:0] pos,
			input logic [START_W-1:0] tail, input logic [RING_W-1:0] ring);
		dist_t p;
		dist_t t;
		dist_t r;
		p = dist_t'({5'd0, pos});
		t = dist_t'({5'd0, tail});
		r = dist_t'({4'd0, ring});
		if (tail <= pos) begin
			return p - t;
		end
		return p + r - t;
	endfunction

	function automatic logic [ENT_LEN_W-1:0] sat_len(input dist_t v);
		if (v < 0) begin
			return '0;
		end
		if (v > dist_t'(21'sd262143)) begin
			return '1;
		end
		return v[ENT_LEN_W-1:0];
	endfunction

endpackage

@@ rtl/core/rbm_seg_if.sv @@
interface rbm_seg_if;
	import rbm_pkg::*;
	logic valid;
	logic ready;
	logic [START_W-1:0] seg_start;
	logic [SEG_LEN_W-1:0] seg_len;
	logic [START_W-1:0] tail_pos;
	modport source (output valid, output seg_start, output seg_len, output tail_pos,
		input ready);
	modport sink (input valid, input seg_start, input seg_len, input tail_pos,
		output ready);
endinterface

@@ rtl/core/rbm_res_if.sv @@
interface rbm_res_if;
	import rbm_pkg::*;
	logic valid;
	logic ready;
	logic [OUT_W-1:0] in_order_len;
	modport source (output valid, output in_order_len, input ready);
	modport sink (input valid, input in_order_len, output ready);
endinterface

@@ rtl/core/reassembly_block_merger_core.sv @@
// Out-of-order range table for a receive ring. Ranges live in a single-port-read
// memory used as a ring of MAX_BLOCKS slots (oldest at the head). An item is
// accepted while the block is idle, then the stored entries are streamed out of
// the memory one per cycle, merged or compacted back in order, and a final
// write-back state, which waits until the result register is free, stores the new
// range (for an item that is not in order) and loads the result; the entries are
// scanned one at a time because of the one read port.
// A new item can be accepted while the previous result still waits to be taken.
module reassembly_block_merger_core #(
	parameter int MAX_BLOCKS = rbm_pkg::RBM_MAX_BLOCKS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [rbm_pkg::RING_W-1:0] cfg_wdata,
	rbm_seg_if.sink seg,
	rbm_res_if.source res
);
	import rbm_pkg::*;

	localparam int IW = $clog2(MAX_BLOCKS);
	localparam int CW = $clog2(MAX_BLOCKS + 1);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_WB   = 3'b100
	} state_t;

	state_t state_q;
	logic [RING_W-1:0] ring_q;
	logic [CW-1:0] cnt_q, rd_cnt_q, wr_cnt_q;
	logic [IW-1:0] head_q, rd_ph_q, wr_ph_q;
	logic vld_s1;
	logic ino_q;
	dist_t pl_q, pr_q;
	logic [START_W-1:0] start_q, tail_q;
	logic out_vld_q;
	logic [OUT_W-1:0] out_len_q;

	rbm_entry_t rdata, wdata;
	logic we, re;
	logic [IW-1:0] waddr;
	dist_t pb, pe, pl_in;
	logic merge, rd_issue, out_free;

	function automatic logic [IW-1:0] inc_ph(input logic [IW-1:0] p);
		return (p == IW'(MAX_BLOCKS - 1)) ? '0 : p + IW'(1);
	endfunction

	rbm_table #(.MAX_BLOCKS(MAX_BLOCKS)) u_table (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.re(re), .raddr(rd_ph_q), .rdata(rdata)
	);

	assign seg.ready = (state_q == ST_IDLE);
	assign res.valid = out_vld_q;
	assign res.in_order_len = out_len_q;
	assign out_free = !out_vld_q || res.ready;

	assign pl_in = (seg.seg_start == seg.tail_pos) ? '0 :
		dist_from(seg.seg_start, seg.tail_pos, ring_q);
	assign pb = dist_from(rdata.start, tail_q, ring_q);
	assign pe = pb + dist_t'({3'd0, rdata.len});
	assign merge = ino_q ? (pb <= pr_q) : ((pl_q <= pe) && (pb <= pr_q));
	assign rd_issue = (state_q == ST_SCAN) && (rd_cnt_q != cnt_q);
	assign re = rd_issue;

	always_comb begin
		we = 1'b0;
		waddr = wr_ph_q;
		wdata = rdata;
		if (state_q == ST_SCAN && vld_s1 && !merge) begin
			we = 1'b1;
		end else if (state_q == ST_WB && out_free && !ino_q) begin
			we = 1'b1;
			wdata.start = start_q;
			wdata.len = sat_len(pr_q - pl_q);
			if (wr_cnt_q == CW'(MAX_BLOCKS)) begin
				waddr = head_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_q <= RING_RESET;
		end else if (cfg_we) begin
			ring_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			head_q <= '0;
			rd_cnt_q <= '0;
			wr_cnt_q <= '0;
			rd_ph_q <= '0;
			wr_ph_q <= '0;
			vld_s1 <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (res.ready && !(state_q == ST_WB && out_free)) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (seg.valid) begin
						state_q <= ST_SCAN;
						rd_cnt_q <= '0;
						wr_cnt_q <= '0;
						rd_ph_q <= head_q;
						wr_ph_q <= head_q;
						vld_s1 <= 1'b0;
					end
				end
				ST_SCAN: begin
					vld_s1 <= rd_issue;
					if (rd_issue) begin
						rd_cnt_q <= rd_cnt_q + CW'(1);
						rd_ph_q <= inc_ph(rd_ph_q);
					end
					if (vld_s1 && !merge) begin
						wr_cnt_q <= wr_cnt_q + CW'(1);
						wr_ph_q <= inc_ph(wr_ph_q);
					end
					if (!rd_issue && !vld_s1) begin
						state_q <= ST_WB;
					end
				end
				ST_WB: begin
					if (out_free) begin
						out_vld_q <= 1'b1;
						state_q <= ST_IDLE;
						if (ino_q) begin
							cnt_q <= wr_cnt_q;
						end else if (wr_cnt_q == CW'(MAX_BLOCKS)) begin
							head_q <= inc_ph(head_q);
						end else begin
							cnt_q <= wr_cnt_q + CW'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && seg.valid) begin
			ino_q <= (seg.seg_start == seg.tail_pos);
			start_q <= seg.seg_start;
			tail_q <= seg.tail_pos;
			pl_q <= pl_in;
			pr_q <= pl_in + dist_t'({4'd0, seg.seg_len});
		end else if (state_q == ST_SCAN && vld_s1 && merge) begin
			if (pe > pr_q) begin
				pr_q <= pe;
			end
			if (!ino_q && pb < pl_q) begin
				pl_q <= pb;
				start_q <= rdata.start;
			end
		end
		if (state_q == ST_WB && out_free) begin
			out_len_q <= ino_q ? sat_len(pr_q - pl_q) : '0;
		end
	end

`ifndef NO_ASSERTIONS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_BLOCKS))
		else $error("entry count above table depth");
	a_compact: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> wr_cnt_q <= rd_cnt_q)
		else $error("compaction write ahead of read");
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		seg.valid && seg.ready |=> state_q == ST_SCAN)
		else $error("accepted item did not start a scan");
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WB && out_free |=> out_vld_q && state_q == ST_IDLE)
		else $error("write-back did not load the result");
`endif
endmodule

@@ rtl/core/rbm_table.sv @@
module rbm_table #(
	parameter int MAX_BLOCKS = rbm_pkg::RBM_MAX_BLOCKS
) (
	input  logic clk,
	input  logic we,
	input  logic [$clog2(MAX_BLOCKS)-1:0] waddr,
	input  rbm_pkg::rbm_entry_t wdata,
	input  logic re,
	input  logic [$clog2(MAX_BLOCKS)-1:0] raddr,
	output rbm_pkg::rbm_entry_t rdata
);
	import rbm_pkg::*;

	rbm_entry_t mem [MAX_BLOCKS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

@@ bench/rbm_tb_if.sv @@
`timescale 1ns / 100ps
// the block's own channel interfaces are used; this file carries the item struct
package rbm_tb_pkg;
	import rbm_pkg::*;
	typedef struct {
		logic [START_W-1:0] seg_start;
		logic [SEG_LEN_W-1:0] seg_len;
		logic [START_W-1:0] tail_pos;
	} seg_item_t;
endpackage

@@ bench/tb_reassembly_block_merger_core.sv @@
`timescale 1ns / 100ps
module tb_reassembly_block_merger_core;
	import rbm_pkg::*;
	import rbm_tb_pkg::*;

	class merge_scoreboard;
		logic [RING_W-1:0] ring;
		logic [START_W-1:0] ent_start [RBM_MAX_BLOCKS];
		longint ent_len [RBM_MAX_BLOCKS];
		bit ent_used [RBM_MAX_BLOCKS];
		logic [OUT_W-1:0] pending_len [$];
		int errors;
		int seen;
		int nonzero;

		function new();
			ring = RING_RESET;
			foreach (ent_used[k]) begin
				ent_used[k] = 0;
				ent_start[k] = '0;
				ent_len[k] = 0;
			end
			errors = 0;
			seen = 0;
			nonzero = 0;
		endfunction

		function longint span(longint p, longint t);
			if (t <= p) begin
				return p - t;
			end
			return p + longint'(ring) - t;
		endfunction

		function longint clip(longint v);
			if (v < 0) begin
				return 0;
			end
			if (v > 262143) begin
				return 262143;
			end
			return v;
		endfunction

		function void remove_slot(int idx);
			for (int k = idx; k + 1 < RBM_MAX_BLOCKS; k++) begin
				ent_start[k] = ent_start[k + 1];
				ent_len[k] = ent_len[k + 1];
				ent_used[k] = ent_used[k + 1];
			end
			ent_start[RBM_MAX_BLOCKS - 1] = '0;
			ent_len[RBM_MAX_BLOCKS - 1] = 0;
			ent_used[RBM_MAX_BLOCKS - 1] = 0;
		endfunction

		function void note_segment(seg_item_t s);
			logic [START_W-1:0] st;
			longint len;
			longint pl;
			longint pr;
			longint pb;
			longint pe;
			int i;
			st = s.seg_start;
			len = s.seg_len;
			pl = span(s.seg_start, s.tail_pos);
			pr = pl + len;
			i = 0;
			if (s.seg_start == s.tail_pos) begin
				while (i < RBM_MAX_BLOCKS && ent_used[i]) begin
					pb = span(ent_start[i], s.tail_pos);
					if (pb <= pr) begin
						if (pb + ent_len[i] > pr) begin
							pr = pb + ent_len[i];
						end
						len = pr - pl;
						remove_slot(i);
					end else begin
						i++;
					end
				end
				pending_len.push_back(OUT_W'(clip(len)));
				return;
			end
			while (i < RBM_MAX_BLOCKS && ent_used[i]) begin
				pb = span(ent_start[i], s.tail_pos);
				pe = pb + ent_len[i];
				if (pl <= pe && pb <= pr) begin
					if (pe > pr) begin
						pr = pe;
					end
					if (pb < pl) begin
						pl = pb;
						st = ent_start[i];
					end
					len = pr - pl;
					remove_slot(i);
				end else begin
					i++;
				end
			end
			if (i >= RBM_MAX_BLOCKS) begin
				remove_slot(0);
				i = RBM_MAX_BLOCKS - 1;
			end
			ent_start[i] = st;
			ent_len[i] = clip(len);
			ent_used[i] = 1;
			pending_len.push_back('0);
		endfunction

		function void check_result(logic [OUT_W-1:0] got);
			logic [OUT_W-1:0] want;
			seen++;
			if (got != 0) begin
				nonzero++;
			end
			if (pending_len.size() == 0) begin
				$display("%0t: unexpected result in_order_len=%0d", $time, got);
				errors++;
				return;
			end
			want = pending_len.pop_front();
			if (got !== want) begin
				$display("%0t: in_order_len expected %0d actual %0d", $time, want, got);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [RING_W-1:0] cfg_wdata;
	rbm_seg_if seg ();
	rbm_res_if res ();
	merge_scoreboard board;
	int items_sent;
	int cfg_writes;

	reassembly_block_merger_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.seg(seg.sink),
		.res(res.source)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	always @(posedge clk) begin
		if (res.valid && res.ready) begin
			board.check_result(res.in_order_len);
		end
	end

	initial begin
		int stall;
		res.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = gap_len();
			@(posedge clk);
			if (stall > 0) begin
				res.ready <= 1'b0;
				repeat (stall - 1) @(posedge clk);
			end else begin
				res.ready <= 1'b1;
			end
		end
	end

	task automatic send_seg(seg_item_t s, bit pace);
		int g;
		g = pace ? gap_len() : 0;
		if (g > 0) begin
			seg.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		seg.valid <= 1'b1;
		seg.seg_start <= s.seg_start;
		seg.seg_len <= s.seg_len;
		seg.tail_pos <= s.tail_pos;
		@(posedge clk);
		while (!seg.ready) begin
			@(posedge clk);
		end
		board.note_segment(s);
		items_sent++;
	endtask

	task automatic drain();
		seg.valid <= 1'b0;
		@(posedge clk);
		while (board.pending_len.size() != 0) begin
			@(posedge clk);
		end
		repeat (RBM_MAX_BLOCKS + 8) @(posedge clk);
	endtask

	task automatic write_ring(logic [RING_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.ring = v;
		cfg_writes++;
	endtask

	function automatic seg_item_t make_seg(int sv, int lv, int tv);
		seg_item_t s;
		s.seg_start = START_W'(sv);
		s.seg_len = SEG_LEN_W'(lv);
		s.tail_pos = START_W'(tv);
		return s;
	endfunction

	// stream of ranges around a moving tail, mostly near it
	task automatic random_phase(int count, int span_max);
		int tail;
		int off;
		seg_item_t s;
		tail = $urandom_range(0, 65535);
		for (int n = 0; n < count; n++) begin
			case ($urandom_range(0, 9))
				0: s = make_seg($urandom_range(0, 65535), $urandom_range(0, 131071),
					$urandom_range(0, 65535));
				1, 2: begin
					s = make_seg(tail, $urandom_range(0, span_max), tail);
					tail = (tail + s.seg_len) & 16'hffff;
				end
				default: begin
					off = $urandom_range(1, span_max);
					s = make_seg((tail + off) & 16'hffff, $urandom_range(0, span_max), tail);
				end
			endcase
			if ($urandom_range(0, 19) == 0) begin
				s.seg_len = SEG_LEN_W'($urandom_range(60000, 131071));
			end
			send_seg(s, n % 200 < 150);
		end
	endtask

	initial begin
		board = new();
		items_sent = 0;
		cfg_writes = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		seg.valid = 1'b0;
		seg.seg_start = '0;
		seg.seg_len = '0;
		seg.tail_pos = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_seg(make_seg(100, 10, 0), 1);
		send_seg(make_seg(110, 5, 0), 1);
		send_seg(make_seg(300, 0, 0), 1);
		send_seg(make_seg(0, 100, 0), 1);
		send_seg(make_seg(65535, 131071, 65535), 1);
		for (int k = 0; k < 10; k++) begin
			send_seg(make_seg(1000 + 50 * k, 10, 500), 1);
		end
		send_seg(make_seg(400, 65536, 500), 1);
		send_seg(make_seg(65535, 131071, 0), 1);
		send_seg(make_seg(0, 131071, 1), 1);
		send_seg(make_seg(500, 0, 500), 1);
		send_seg(make_seg(0, 0, 0), 1);
		drain();

		random_phase(500, 2000);
		drain();
		write_ring(1);
		random_phase(150, 3);
		drain();
		write_ring(131071);
		random_phase(250, 40000);
		drain();
		write_ring(0);
		random_phase(150, 500);
		drain();
		write_ring(1000);
		random_phase(300, 300);
		drain();
		write_ring(65536);
		random_phase(450, 64);
		drain();

		$display("sent %0d ranges over %0d ring sizes, %0d results checked, %0d in order",
			items_sent, cfg_writes + 1, board.seen, board.nonzero);
		if (board.errors == 0 && board.pending_len.size() == 0) begin
			$display("PASS reassembly_block_merger_core");
		end else begin
			$display("FAIL reassembly_block_merger_core");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("FAIL reassembly_block_merger_core");
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/rbm_pkg.sv
rtl/core/rbm_seg_if.sv
rtl/core/rbm_res_if.sv
rtl/core/rbm_table.sv
rtl/core/reassembly_block_merger_core.sv
bench/rbm_tb_if.sv
bench/tb_reassembly_block_merger_core.sv
